### design/apu_pkg.sv
// apu_pkg: shared constants of the adam parameter update block
// opcodes, register indexes, reset values and store geometry
// used by design/adam_parameter_update.sv, depends on nothing
package apu_pkg;

  localparam int NUM_PARAMS = 256;
  localparam int IDX_W      = 8;
  localparam int DEPTH      = 1 << IDX_W;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 5;

  // item opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_LR     = 3'd0;
  localparam logic [2:0] REG_BETA1  = 3'd1;
  localparam logic [2:0] REG_BETA2  = 3'd2;
  localparam logic [2:0] REG_NOISE  = 3'd3;
  localparam logic [2:0] REG_AMS    = 3'd4;
  localparam logic [2:0] REG_TOL    = 3'd5;
  localparam logic [2:0] REG_LIMIT  = 3'd6;

  // register reset values
  localparam logic [23:0] LR_RESET    = 24'd16777;
  localparam logic [15:0] BETA1_RESET = 16'd58982;
  localparam logic [15:0] BETA2_RESET = 16'd64881;
  localparam logic [15:0] NOISE_RESET = 16'd1;
  localparam logic [15:0] LIMIT_RESET = 16'd10000;

  // 1.0 in unsigned q1.31
  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  // cap of the parameter step
  localparam logic [33:0] STEP_CAP = 34'h2_0000_0000;

endpackage

### design/adam_parameter_update.sv
// adam_parameter_update: adam / amsgrad parameter update engine, signed q16.16
// one sequencer, a shared 32x32 multiplier, bit-serial square root and divider
// depends on apu_pkg (design/apu_pkg.sv)
//
// timing: load, clear and unused opcodes go from accept through decode to done;
// an update runs the 24-step root and the 34-step divide; the first update of a
// pass also runs the 32-step root and 32-step divide of the bias-corrected rate.
// one item at a time; the next is accepted as soon as the result sits in the
// output register.
// reset: synchronous, clears config to defaults, moments, counters and powers
module adam_parameter_update
  import apu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               opcode,
  input  logic [IDX_W-1:0]         element_index,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_index,
  output logic signed [DATA_W-1:0] parameter_value,
  output logic                     pass_end,
  output logic                     converged,
  output logic                     limit_reached,
  output logic [31:0]              step_count,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  typedef enum logic [22:0] {
    S_IDLE  = 23'b1 << 0,
    S_DEC   = 23'b1 << 1,
    S_P1    = 23'b1 << 2,
    S_P2    = 23'b1 << 3,
    S_P3    = 23'b1 << 4,
    S_P4    = 23'b1 << 5,
    S_P5    = 23'b1 << 6,
    S_SQRT  = 23'b1 << 7,
    S_DIV   = 23'b1 << 8,
    S_RATE  = 23'b1 << 9,
    S_GSQ   = 23'b1 << 10,
    S_NORM  = 23'b1 << 11,
    S_M1    = 23'b1 << 12,
    S_M2    = 23'b1 << 13,
    S_V1    = 23'b1 << 14,
    S_V2    = 23'b1 << 15,
    S_V3    = 23'b1 << 16,
    S_DEN   = 23'b1 << 17,
    S_QUO   = 23'b1 << 18,
    S_UPD   = 23'b1 << 19,
    S_TOL   = 23'b1 << 20,
    S_FLAGS = 23'b1 << 21,
    S_DONE  = 23'b1 << 22
  } state_t;

  state_t state;

  // configuration registers
  logic [23:0] lr;
  logic [15:0] beta1, beta2, noise, limit;
  logic        ams;
  logic [30:0] tol;

  // captured item
  logic [1:0]       op_r;
  logic [IDX_W-1:0] idx_r;
  logic [31:0]      g_r;
  logic             last_r, ok_r;

  // step state
  logic [31:0] time_step;
  logic [15:0] pass_count;
  logic [31:0] bfp1, bfp2;
  logic [31:0] rate;
  logic [63:0] norm;
  logic        pass_open;
  logic        setup;       // working on the rate of a new pass

  // stores: params undefined until written, moments gated by valid bits
  logic [31:0] p_mem [DEPTH];
  logic [31:0] m_mem [DEPTH];
  logic [31:0] v_mem [DEPTH];
  logic [31:0] x_mem [DEPTH];
  logic [31:0] p_rd, m_rd, v_rd, x_rd;
  logic [DEPTH-1:0] mvalid;

  // datapath registers
  logic [63:0] prod;
  logic [47:0] t1, t3;
  logic [63:0] acc;
  logic [46:0] g16;
  logic [31:0] m_new, mmag, v_new, x_new, dq, pval;
  logic        m_neg;
  logic [24:0] denom;
  logic [33:0] quo;
  logic        r_pend, r_conv, r_lim;

  // bit-serial root and divide
  logic [63:0] sq_x;
  logic [33:0] sq_rem;
  logic [31:0] sq_root;
  logic [32:0] dv;
  logic [33:0] dv_rem, dv_lo;
  logic [5:0]  cnt;

  logic in_acc, cfg_wr;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  // configuration readback
  always_comb begin
    case (paddr[4:2])
      REG_LR:    prdata = {8'b0, lr};
      REG_BETA1: prdata = {16'b0, beta1};
      REG_BETA2: prdata = {16'b0, beta2};
      REG_NOISE: prdata = {16'b0, noise};
      REG_AMS:   prdata = {31'b0, ams};
      REG_TOL:   prdata = {1'b0, tol};
      REG_LIMIT: prdata = {16'b0, limit};
      default:   prdata = '0;
    endcase
  end

  // effective old values of the addressed entry
  logic [31:0] m_eff, v_eff, x_eff, gmag, mmag_eff;
  logic        g_neg;
  assign m_eff    = mvalid[idx_r] ? m_rd : '0;
  assign v_eff    = mvalid[idx_r] ? v_rd : '0;
  assign x_eff    = mvalid[idx_r] ? x_rd : '0;
  assign g_neg    = g_r[31];
  assign gmag     = g_neg ? (32'd0 - g_r) : g_r;
  assign mmag_eff = m_eff[31] ? (32'd0 - m_eff) : m_eff;

  logic [16:0] c1, c2;
  assign c1 = 17'h1_0000 - {1'b0, beta1};
  assign c2 = 17'h1_0000 - {1'b0, beta2};

  // shared multiplier, product registered every cycle
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_P1:    begin mul_a = bfp1;            mul_b = {16'b0, beta1}; end
      S_P2:    begin mul_a = bfp2;            mul_b = {16'b0, beta2}; end
      S_P4:    begin mul_a = {8'b0, lr};      mul_b = sq_root; end
      S_GSQ:   begin mul_a = gmag;            mul_b = gmag; end
      S_NORM:  begin mul_a = {16'b0, beta1};  mul_b = mmag_eff; end
      S_M1:    begin mul_a = {15'b0, c1};     mul_b = gmag; end
      S_M2:    begin mul_a = {16'b0, beta2};  mul_b = v_eff; end
      S_V1:    begin mul_a = {15'b0, c2};     mul_b = g16[31:0]; end
      S_V2:    begin mul_a = {15'b0, c2};     mul_b = {17'b0, g16[46:32]}; end
      S_DEN:   begin mul_a = rate;            mul_b = mmag; end
      S_TOL:   begin mul_a = {1'b0, tol};     mul_b = {1'b0, tol}; end
      default: begin mul_a = '0;              mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // beta power rounding
  logic [63:0] p_rnd64;
  logic [31:0] bfp_rnd;
  assign p_rnd64 = prod + 64'd32768;
  assign bfp_rnd = p_rnd64[47:16];

  // rate numerator and overflow check
  logic [63:0] np;
  logic        ovf_p;
  assign np    = prod + {33'b0, dq[31:1]};
  assign ovf_p = np >= {dq, 32'b0};

  // norm saturating add and squared gradient in q16.16
  logic [64:0] nsum;
  assign nsum = {1'b0, norm} + {1'b0, prod};

  // first moment: signed combination, round half away from zero, saturate
  logic [50:0] s_a, s_b, s_sum, s_mag, s_rnd;
  logic [34:0] r_mag;
  logic        s_neg;
  logic [31:0] mm_c;
  logic        mneg_c;
  assign s_a   = m_eff[31] ? (51'd0 - {3'b0, t1}) : {3'b0, t1};
  assign s_b   = g_neg ? (51'd0 - {2'b0, prod[48:0]}) : {2'b0, prod[48:0]};
  assign s_sum = s_a + s_b;
  assign s_neg = s_sum[50];
  assign s_mag = s_neg ? (51'd0 - s_sum) : s_sum;
  assign s_rnd = s_mag + 51'd32768;
  assign r_mag = s_rnd[50:16];
  always_comb begin
    if (s_neg) mm_c = (r_mag > 35'h0_8000_0000) ? 32'h8000_0000 : r_mag[31:0];
    else       mm_c = (r_mag > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r_mag[31:0];
  end
  assign mneg_c = s_neg && (r_mag != '0);

  // second moment and running max
  logic [63:0] vsum;
  logic [31:0] v_c, x_c, mom_c;
  assign vsum  = acc + {prod[31:0], 32'b0};
  assign v_c   = (vsum[63:48] != '0) ? 32'hFFFF_FFFF : vsum[47:16];
  assign x_c   = (ams && (v_c > x_eff)) ? v_c : x_eff;
  assign mom_c = ams ? x_c : v_c;

  // denominator and step numerator
  logic [24:0] den_c;
  logic [32:0] div_c;
  logic [63:0] nq;
  logic        ovf_q;
  assign den_c = sq_root[24:0] + {9'b0, noise};
  assign div_c = {denom, 8'b0};
  assign nq    = prod + {32'b0, denom, 7'b0};
  assign ovf_q = {3'b0, nq} >= {div_c, 34'b0};

  // parameter update
  logic [33:0]        q_c;
  logic signed [35:0] psum;
  logic [31:0]        pval_c;
  assign q_c  = (quo > STEP_CAP) ? STEP_CAP : quo;
  assign psum = $signed({{4{p_rd[31]}}, p_rd})
              + (m_neg ? $signed({2'b0, q_c}) : -$signed({2'b0, q_c}));
  always_comb begin
    if (psum > 36'sh0_7FFF_FFFF)       pval_c = 32'h7FFF_FFFF;
    else if (psum < -36'sh0_8000_0000) pval_c = 32'h8000_0000;
    else                               pval_c = psum[31:0];
  end

  // pass end flags
  logic [15:0] pc_next;
  assign pc_next = (pass_count == 16'hFFFF) ? pass_count : pass_count + 16'd1;

  // root step: two input bits per cycle
  logic [34:0] sq_sh, sq_trial;
  logic        sq_ge;
  assign sq_sh    = {sq_rem[32:0], sq_x[63:62]};
  assign sq_trial = {1'b0, sq_root, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  // divide step: one quotient bit per cycle
  logic [33:0] dv_sh;
  logic        dv_ge;
  assign dv_sh = {dv_rem[32:0], dv_lo[33]};
  assign dv_ge = dv_sh >= {1'b0, dv};

  // store writes
  logic p_we, mom_we;
  logic [31:0] p_wd;
  assign p_we   = ((state == S_DEC) && (op_r == OP_LOAD) && ok_r) || (state == S_UPD);
  assign p_wd   = (state == S_DEC) ? g_r : pval_c;
  assign mom_we = (state == S_UPD);

  always_ff @(posedge clk) begin
    if (p_we) p_mem[idx_r] <= p_wd;
    if (in_acc) p_rd <= p_mem[element_index];
  end
  always_ff @(posedge clk) begin
    if (mom_we) m_mem[idx_r] <= m_new;
    if (in_acc) m_rd <= m_mem[element_index];
  end
  always_ff @(posedge clk) begin
    if (mom_we) v_mem[idx_r] <= v_new;
    if (in_acc) v_rd <= v_mem[element_index];
  end
  always_ff @(posedge clk) begin
    if (mom_we) x_mem[idx_r] <= x_new;
    if (in_acc) x_rd <= x_mem[element_index];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lr    <= LR_RESET;
      beta1 <= BETA1_RESET;
      beta2 <= BETA2_RESET;
      noise <= NOISE_RESET;
      ams   <= 1'b0;
      tol   <= '0;
      limit <= LIMIT_RESET;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_LR:    lr    <= pwdata[23:0];
        REG_BETA1: beta1 <= pwdata[15:0];
        REG_BETA2: beta2 <= pwdata[15:0];
        REG_NOISE: noise <= pwdata[15:0];
        REG_AMS:   ams   <= pwdata[0];
        REG_TOL:   tol   <= pwdata[30:0];
        REG_LIMIT: limit <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      mvalid     <= '0;
      time_step  <= '0;
      pass_count <= '0;
      bfp1       <= ONE_Q31;
      bfp2       <= ONE_Q31;
      rate       <= '0;
      norm       <= '0;
      pass_open  <= 1'b0;
      setup      <= 1'b0;
    end else begin
      // result taken and no new one behind it
      if (out_valid && !out_stall && (state != S_DONE)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op_r   <= opcode;
            idx_r  <= element_index;
            g_r    <= value;
            last_r <= last;
            ok_r   <= {9'b0, element_index} < 17'(NUM_PARAMS);
            state  <= S_DEC;
          end
        end
        S_DEC: begin
          r_pend <= 1'b0;
          r_conv <= 1'b0;
          r_lim  <= 1'b0;
          pval   <= '0;
          case (op_r)
            OP_LOAD: begin
              if (ok_r) begin
                pval          <= g_r;
                mvalid[idx_r] <= 1'b0;
                pass_count    <= '0;
              end
              state <= S_DONE;
            end
            OP_CLEAR: begin
              mvalid     <= '0;
              time_step  <= '0;
              pass_count <= '0;
              bfp1       <= ONE_Q31;
              bfp2       <= ONE_Q31;
              rate       <= '0;
              norm       <= '0;
              pass_open  <= 1'b0;
              state      <= S_DONE;
            end
            OP_UPDATE: begin
              if (!pass_open) begin
                setup <= 1'b1;
                state <= S_P1;
              end else begin
                state <= S_GSQ;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        // new pass: step, beta powers, corrected rate
        S_P1: begin
          if (time_step != 32'hFFFF_FFFF) time_step <= time_step + 32'd1;
          norm      <= '0;
          pass_open <= 1'b1;
          state     <= S_P2;
        end
        S_P2: begin
          bfp1  <= bfp_rnd;
          state <= S_P3;
        end
        S_P3: begin
          bfp2    <= bfp_rnd;
          dq      <= ONE_Q31 - bfp1;
          sq_x    <= {1'b0, ONE_Q31 - bfp_rnd, 31'b0};
          sq_rem  <= '0;
          sq_root <= '0;
          cnt     <= 6'd31;
          state   <= S_SQRT;
        end
        S_SQRT: begin
          sq_rem  <= sq_ge ? 34'(sq_sh - sq_trial) : sq_sh[33:0];
          sq_root <= {sq_root[30:0], sq_ge};
          sq_x    <= {sq_x[61:0], 2'b00};
          cnt     <= cnt - 6'd1;
          if (cnt == '0) state <= setup ? S_P4 : S_DEN;
        end
        S_P4: state <= S_P5;
        S_P5: begin
          if (dq == '0 || ovf_p) begin
            rate  <= 32'hFFFF_FFFF;
            setup <= 1'b0;
            state <= S_GSQ;
          end else begin
            dv     <= {1'b0, dq};
            dv_rem <= {2'b0, np[63:32]};
            dv_lo  <= {np[31:0], 2'b00};
            quo    <= '0;
            cnt    <= 6'd31;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          dv_rem <= dv_ge ? (dv_sh - {1'b0, dv}) : dv_sh;
          quo    <= {quo[32:0], dv_ge};
          dv_lo  <= {dv_lo[32:0], 1'b0};
          cnt    <= cnt - 6'd1;
          if (cnt == '0) state <= setup ? S_RATE : S_UPD;
        end
        S_RATE: begin
          rate  <= quo[31:0];
          setup <= 1'b0;
          state <= S_GSQ;
        end
        // element: squared gradient and norm
        S_GSQ: state <= S_NORM;
        S_NORM: begin
          norm <= nsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : nsum[63:0];
          g16  <= p_rnd64[62:16];
          if (ok_r)        state <= S_M1;
          else if (last_r) state <= S_TOL;
          else             state <= S_DONE;
        end
        S_M1: begin
          t1    <= prod[47:0];
          state <= S_M2;
        end
        S_M2: begin
          mmag  <= mm_c;
          m_neg <= mneg_c;
          m_new <= mneg_c ? (32'd0 - mm_c) : mm_c;
          state <= S_V1;
        end
        S_V1: begin
          t3    <= prod[47:0];
          state <= S_V2;
        end
        S_V2: begin
          acc   <= {16'b0, t3} + prod + 64'd32768;
          state <= S_V3;
        end
        S_V3: begin
          v_new   <= v_c;
          x_new   <= x_c;
          sq_x    <= {mom_c, 32'b0};
          sq_rem  <= '0;
          sq_root <= '0;
          cnt     <= 6'd23;
          state   <= S_SQRT;
        end
        S_DEN: begin
          denom <= (den_c == '0) ? 25'd1 : den_c;
          state <= S_QUO;
        end
        S_QUO: begin
          if (ovf_q) begin
            quo   <= STEP_CAP;
            state <= S_UPD;
          end else begin
            dv     <= div_c;
            dv_rem <= {4'b0, nq[63:34]};
            dv_lo  <= nq[33:0];
            quo    <= '0;
            cnt    <= 6'd33;
            state  <= S_DIV;
          end
        end
        S_UPD: begin
          pval          <= pval_c;
          mvalid[idx_r] <= 1'b1;
          state         <= last_r ? S_TOL : S_DONE;
        end
        // pass end: norm against tolerance squared, pass count against limit
        S_TOL: state <= S_FLAGS;
        S_FLAGS: begin
          pass_count <= pc_next;
          r_pend     <= 1'b1;
          r_conv     <= norm < prod;
          r_lim      <= pc_next >= limit;
          pass_open  <= 1'b0;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register, loaded as the item leaves the sequencer
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      out_index       <= idx_r;
      parameter_value <= pval;
      pass_end        <= r_pend;
      converged       <= r_conv;
      limit_reached   <= r_lim;
      step_count      <= time_step;
    end
  end

endmodule
